@@ sv/tbw_pkg.sv @@
package tbw_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned WEIGHT_BITS    = 32;
endpackage

@@ sv/tetrahedron_barycentric_weights_core.sv @@
// Barycentric weights of a query point in a tetrahedron.
// Input channel: in_tdata carries four vertices and the query point, each three
// signed coordinates packed x,y,z from the lowest bit. Output channel: out_tdata
// carries four signed Q16.16 weights and the degenerate flag.
// Each weight is the determinant with that vertex replaced by the point, divided
// by the sum of all four (the volume determinant). A zero sum raises degenerate
// and forces all weights to the largest positive value; out-of-range quotients
// saturate.
// Throughput: one item per cycle unless the receiver stalls. Five stages form the
// edge vectors, the minors, the cofactor products, the determinants and the sum
// with magnitudes; a restoring divider then retires one quotient bit per stage
// (3*(COORD_BITS+1)+4+FRAC_BITS = 71 stages, four lanes side by side); one last
// register signs and saturates.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, every stage holds; in_tready is low exactly while
// out_tvalid is high and out_tready is low, so nothing is dropped or repeated.
module tetrahedron_barycentric_weights_core
  import tbw_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // vertex_a, vertex_b, vertex_c, vertex_d, query_point (3*COORD_BITS each)
  input  logic [((15*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // weight_a, weight_b, weight_c, weight_d (32 each), degenerate
  output logic [135:0] out_tdata
);
  localparam int unsigned CB  = COORD_BITS;
  localparam int unsigned DB  = CB + 1;            // differences
  localparam int unsigned PB  = 2 * DB;            // 2x2 products
  localparam int unsigned MB  = 3 * DB + 2;        // 3x3 determinant
  localparam int unsigned SB  = MB + 2;            // sum of four
  localparam int unsigned NB  = SB + FRAC_BITS;    // dividend magnitude
  localparam int unsigned QB  = NB;                // quotient bits
  localparam int unsigned W   = WEIGHT_BITS;

  typedef logic signed [CB-1:0] crd_t;
  typedef logic signed [DB-1:0] dif_t;
  typedef logic signed [PB-1:0] prd_t;
  typedef logic signed [MB-1:0] det_t;
  typedef logic signed [SB-1:0] sum_t;

  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  // unpack
  crd_t pin [5][3];
  always_comb begin
    for (int v = 0; v < 5; v++)
      for (int k = 0; k < 3; k++)
        pin[v][k] = in_tdata[(3*v+k)*CB +: CB];
  end

  // stage 1: edge vectors per determinant (other rows minus row 0)
  logic s1_v_r;
  dif_t s1_a_r [4][3], s1_b_r [4][3], s1_c_r [4][3];
  crd_t r [4][4][3];
  always_comb begin
    for (int d = 0; d < 4; d++)
      for (int i = 0; i < 4; i++)
        for (int k = 0; k < 3; k++)
          r[d][i][k] = (i == d) ? pin[4][k] : pin[i][k];
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_tvalid;
    if (adv)
      for (int d = 0; d < 4; d++)
        for (int k = 0; k < 3; k++) begin
          s1_a_r[d][k] <= DB'(r[d][1][k]) - DB'(r[d][0][k]);
          s1_b_r[d][k] <= DB'(r[d][2][k]) - DB'(r[d][0][k]);
          s1_c_r[d][k] <= DB'(r[d][3][k]) - DB'(r[d][0][k]);
        end
  end

  // stage 2: 2x2 minors of b,c
  logic s2_v_r;
  dif_t s2_a_r [4][3];
  prd_t s2_m_r [4][3];
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
    if (adv)
      for (int d = 0; d < 4; d++) begin
        s2_a_r[d] <= s1_a_r[d];
        s2_m_r[d][0] <= s1_b_r[d][1]*s1_c_r[d][2] - s1_b_r[d][2]*s1_c_r[d][1];
        s2_m_r[d][1] <= s1_b_r[d][2]*s1_c_r[d][0] - s1_b_r[d][0]*s1_c_r[d][2];
        s2_m_r[d][2] <= s1_b_r[d][0]*s1_c_r[d][1] - s1_b_r[d][1]*s1_c_r[d][0];
      end
  end

  // stage 3: cofactor products
  logic s3_v_r;
  det_t s3_p_r [4][3];
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (adv) s3_v_r <= s2_v_r;
    if (adv)
      for (int d = 0; d < 4; d++)
        for (int k = 0; k < 3; k++)
          s3_p_r[d][k] <= MB'(s2_a_r[d][k]) * MB'(s2_m_r[d][k]);
  end

  // stage 4: determinants (negated 3x3)
  logic s4_v_r;
  det_t s4_d_r [4];
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (adv) s4_v_r <= s3_v_r;
    if (adv)
      for (int d = 0; d < 4; d++)
        s4_d_r[d] <= -(s3_p_r[d][0] + s3_p_r[d][1] + s3_p_r[d][2]);
  end

  // stage 5: sum, signs, magnitudes
  logic s5_v_r;
  logic [SB-1:0] s5_den_r;
  logic [NB-1:0] s5_num_r [4];
  logic s5_neg_r [4];
  logic s5_deg_r;
  sum_t sum;
  assign sum = SB'(s4_d_r[0]) + SB'(s4_d_r[1]) + SB'(s4_d_r[2]) + SB'(s4_d_r[3]);
  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else if (adv) s5_v_r <= s4_v_r;
    if (adv) begin
      s5_den_r <= sum[SB-1] ? SB'(-sum) : SB'(sum);
      s5_deg_r <= (sum == '0);
      for (int d = 0; d < 4; d++) begin
        s5_neg_r[d] <= s4_d_r[d][MB-1] ^ sum[SB-1];
        s5_num_r[d] <= NB'(s4_d_r[d][MB-1] ? SB'(-SB'(s4_d_r[d])) : SB'(s4_d_r[d]))
                       << FRAC_BITS;
      end
    end
  end

  // divider: one quotient bit per stage, MSB first
  logic          dv_v_r   [1:QB];
  logic [NB-1:0] dv_rem_r [1:QB][4];
  logic [NB-1:0] dv_num_r [1:QB][4];
  logic [SB-1:0] dv_den_r [1:QB];
  logic          dv_neg_r [1:QB][4];
  logic          dv_deg_r [1:QB];
  for (genvar g = 0; g < QB; g++) begin : g_div
    logic          v_in;
    logic [SB-1:0] den_in;
    logic          deg_in;
    logic [NB-1:0] rem_in [4];
    logic [NB-1:0] num_in [4];
    logic          neg_in [4];
    logic [NB:0]   trial [4];
    if (g == 0) begin : g_src
      always_comb begin
        v_in   = s5_v_r;
        den_in = s5_den_r;
        deg_in = s5_deg_r;
        for (int d = 0; d < 4; d++) begin
          rem_in[d] = '0;
          num_in[d] = s5_num_r[d];
          neg_in[d] = s5_neg_r[d];
        end
      end
    end else begin : g_src
      always_comb begin
        v_in   = dv_v_r[g];
        den_in = dv_den_r[g];
        deg_in = dv_deg_r[g];
        for (int d = 0; d < 4; d++) begin
          rem_in[d] = dv_rem_r[g][d];
          num_in[d] = dv_num_r[g][d];
          neg_in[d] = dv_neg_r[g][d];
        end
      end
    end
    always_comb begin
      for (int d = 0; d < 4; d++)
        trial[d] = {rem_in[d], num_in[d][NB-1]} - (NB+1)'(den_in);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[g+1] <= 1'b0;
      else if (adv) dv_v_r[g+1] <= v_in;
      if (adv) begin
        dv_den_r[g+1] <= den_in;
        dv_deg_r[g+1] <= deg_in;
        for (int d = 0; d < 4; d++) begin
          dv_neg_r[g+1][d] <= neg_in[d];
          // remainder stays below the divisor, which fits SB bits
          dv_rem_r[g+1][d] <= trial[d][NB] ?
              {rem_in[d][NB-2:0], num_in[d][NB-1]} : trial[d][NB-1:0];
          dv_num_r[g+1][d] <= {num_in[d][NB-2:0], !trial[d][NB]};
        end
      end
    end
  end

  // output stage: sign and saturate
  logic [W-1:0] w_nxt [4];
  logic [135:0] out_tdata_r;
  logic out_tvalid_r;
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      if (dv_deg_r[QB]) w_nxt[d] = {1'b0, {(W-1){1'b1}}};
      else if (!dv_neg_r[QB][d])
        w_nxt[d] = (dv_num_r[QB][d] > NB'({1'b0, {(W-1){1'b1}}})) ?
                   {1'b0, {(W-1){1'b1}}} : dv_num_r[QB][d][W-1:0];
      else
        w_nxt[d] = (dv_num_r[QB][d] > NB'({1'b1, {(W-1){1'b0}}})) ?
                   {1'b1, {(W-1){1'b0}}} : W'(-dv_num_r[QB][d]);
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (adv) out_tvalid_r <= dv_v_r[QB];
    if (adv)
      out_tdata_r <= {7'd0, dv_deg_r[QB], w_nxt[3], w_nxt[2], w_nxt[1], w_nxt[0]};
  end
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
endmodule

@@ sv/tbw_checker.sv @@
module tbw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [135:0] out_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready) else $error("ready");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[135:129] == 7'd0) else $error("pad");
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[31:0] == 32'h7FFFFFFF
      && out_tdata[127:96] == 32'h7FFFFFFF) else $error("deg");
endmodule

bind tetrahedron_barycentric_weights_core tbw_checker u_tbw_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tbw_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int unsigned FB = FRAC_BITS_DEF;
  localparam int unsigned IN_W = ((15 * CB + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;
  localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] W_MIN = 32'h8000_0000;
  localparam logic [31:0] W_ONE = 32'h0001_0000;

  // One result item: four weights and the flat-tetrahedron flag
  typedef struct packed {
    logic       degenerate;
    logic [31:0] w_d;
    logic [31:0] w_c;
    logic [31:0] w_b;
    logic [31:0] w_a;
  } weights_t;

  // Directed stimulus row; want is used only where has_want is set
  typedef struct {
    logic [IN_W-1:0] data;
    bit              has_want;
    weights_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;

  weights_t weights_q[$];
  int mismatch_cnt = 0;
  int accepted_cnt = 0;
  int stall_cycles = 0;
  bit no_idle = 1'b0;

  tetrahedron_barycentric_weights_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pack one point from three signed coordinates, x in the low slot
  function automatic logic [3*CB-1:0] pt(int x, int y, int z);
    logic [CB-1:0] cx, cy, cz;
    cx = x[CB-1:0];
    cy = y[CB-1:0];
    cz = z[CB-1:0];
    return {cz, cy, cx};
  endfunction

  function automatic longint coord(logic [IN_W-1:0] d, int vtx, int axis);
    logic signed [CB-1:0] c;
    c = d[vtx * 3 * CB + axis * CB +: CB];
    return longint'(c);
  endfunction

  // Determinant of rows (r, 1) through the edge vectors from r0
  function automatic longint det4(longint r[4][3]);
    longint a[3], b[3], c[3], s;
    for (int k = 0; k < 3; k++) begin
      a[k] = r[1][k] - r[0][k];
      b[k] = r[2][k] - r[0][k];
      c[k] = r[3][k] - r[0][k];
    end
    s = a[0] * b[1] * c[2] - a[0] * b[2] * c[1] - a[1] * b[0] * c[2]
      + a[1] * b[2] * c[0] + a[2] * b[0] * c[1] - a[2] * b[1] * c[0];
    return -s;
  endfunction

  // Truncate det/sum toward zero in Q.FB, then saturate to 32 bits
  function automatic logic [31:0] weight_of(longint det, longint sum);
    logic [127:0] num, den, q;
    bit neg;
    neg = (det < 0) != (sum < 0);
    num = 128'(det < 0 ? -det : det) << FB;
    den = 128'(sum < 0 ? -sum : sum);
    q = num / den;
    if (!neg) return (q > 128'(W_MAX)) ? W_MAX : q[31:0];
    return (q > 128'(W_MIN)) ? W_MIN : (~q[31:0] + 32'd1);
  endfunction

  function automatic weights_t predict_weights(logic [IN_W-1:0] d);
    longint v[4][3], p[3], rows[4][3], det[4], sum;
    weights_t w;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++) v[i][k] = coord(d, i, k);
    for (int k = 0; k < 3; k++) p[k] = coord(d, 4, k);
    for (int i = 0; i < 4; i++) begin
      rows = v;
      rows[i] = p;
      det[i] = det4(rows);
    end
    sum = det[0] + det[1] + det[2] + det[3];
    if (sum == 0) begin
      w = '{degenerate: 1'b1, w_a: W_MAX, w_b: W_MAX, w_c: W_MAX, w_d: W_MAX};
    end else begin
      w.degenerate = 1'b0;
      w.w_a = weight_of(det[0], sum);
      w.w_b = weight_of(det[1], sum);
      w.w_c = weight_of(det[2], sum);
      w.w_d = weight_of(det[3], sum);
    end
    return w;
  endfunction

  function automatic logic [3*CB-1:0] rand_pt(int span);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    if (span == 0) return raw[3*CB-1:0];
    return pt($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
              $urandom_range(2 * span) - span);
  endfunction

  // Random item: mostly proper tetrahedra, some flat ones and point-on-vertex
  function automatic logic [IN_W-1:0] rand_item();
    logic [3*CB-1:0] v[5];
    int span;
    case ($urandom_range(9))
      0, 1, 2: span = 0;
      3, 4:    span = 8;
      default: span = $urandom_range(1, 32767);
    endcase
    for (int i = 0; i < 5; i++) v[i] = rand_pt(span);
    case ($urandom_range(9))
      0: v[$urandom_range(1, 3)] = v[0];
      1: v[4] = v[$urandom_range(3)];
      2: v[3] = pt(0, 0, 0);
      default: ;
    endcase
    return {v[4], v[3], v[2], v[1], v[0]};
  endfunction

  function automatic logic [IN_W-1:0] item5(logic [3*CB-1:0] a, b, c, d, p);
    return {p, d, c, b, a};
  endfunction

  // Drive one item: raise valid at the falling edge, hold until accepted
  task automatic send_item(logic [IN_W-1:0] d, weights_t want);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    forever begin
      @(posedge clk);
      if (in_tready) break;
    end
    weights_q.push_back(want);
    accepted_cnt++;
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Sender: directed table first, then random items
  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    weights_t flat, unit_a;
    logic [IN_W-1:0] d;
    flat = '{degenerate: 1'b1, w_a: W_MAX, w_b: W_MAX, w_c: W_MAX, w_d: W_MAX};
    unit_a = '{degenerate: 1'b0, w_a: W_ONE, w_b: 32'd0, w_c: 32'd0, w_d: 32'd0};

    // all zero: flat tetrahedron
    rows.push_back('{'0, 1'b1, flat});
    // unit tetrahedron, point on vertex a
    rows.push_back('{item5(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1),
                           pt(0, 0, 0)), 1'b1, unit_a});
    // same with reversed orientation
    rows.push_back('{item5(pt(0, 0, 0), pt(0, 1, 0), pt(1, 0, 0), pt(0, 0, 1),
                           pt(0, 0, 0)), 1'b1, unit_a});
    // repeated vertex: flat
    rows.push_back('{item5(pt(5, 6, 7), pt(5, 6, 7), pt(-3, 2, 9), pt(1, -8, 4),
                           pt(100, 200, 300)), 1'b1, flat});
    // all inputs at full scale: coincident vertices, flat
    rows.push_back('{{IN_W{1'b1}}, 1'b1, flat});
    // far point on a tiny tetrahedron: saturation both ways
    rows.push_back('{item5(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1),
                           pt(32767, 32767, 32767)), 1'b0, flat});
    rows.push_back('{item5(pt(0, 0, 0), pt(1, 0, 0), pt(0, 1, 0), pt(0, 0, 1),
                           pt(-32768, -32768, -32768)), 1'b0, flat});
    // largest tetrahedron
    rows.push_back('{item5(pt(-32768, -32768, -32768), pt(32767, -32768, -32768),
                           pt(-32768, 32767, -32768), pt(-32768, -32768, 32767),
                           pt(0, 0, 0)), 1'b0, flat});
    rows.push_back('{item5(pt(32767, 32767, 32767), pt(-32768, 32767, 32767),
                           pt(32767, -32768, 32767), pt(32767, 32767, -32768),
                           pt(-32768, -32768, -32768)), 1'b0, flat});
    // centroid-like point with truncation of thirds
    rows.push_back('{item5(pt(0, 0, 0), pt(3, 0, 0), pt(0, 3, 0), pt(0, 0, 3),
                           pt(1, 1, 1)), 1'b0, flat});
    rows.push_back('{item5(pt(0, 0, 0), pt(3, 0, 0), pt(0, 3, 0), pt(0, 0, 3),
                           pt(-1, 2, -1)), 1'b0, flat});
    // coplanar but distinct vertices
    rows.push_back('{item5(pt(0, 0, 0), pt(10, 0, 0), pt(0, 10, 0), pt(7, 3, 0),
                           pt(1, 1, 1)), 1'b1, flat});
    for (int i = 0; i < 8; i++)
      rows.push_back('{rand_item(), 1'b0, flat});

    rst_n <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.data, r.has_want ? r.want : predict_weights(r.data));
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 400 && n < 600);
      if (n == 800) begin
        // pause with nothing offered until the pipe has emptied
        in_tvalid <= 1'b0;
        wait (weights_q.size() == 0);
        @(negedge clk);
      end
      d = rand_item();
      send_item(d, predict_weights(d));
    end
    in_tvalid <= 1'b0;

    wait (weights_q.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && weights_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back up the pipe
  initial begin
    bit held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && accepted_cnt >= 200) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 9);
    end
  end

  // Compare each result item with the oldest expectation; watch for hangs
  always @(posedge clk) begin
    weights_t got, want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[128:0];
        if (weights_q.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) $display("unexpected result item %h", got);
        end else begin
          want = weights_q.pop_front();
          if (got !== want) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("mismatch: exp a=%h b=%h c=%h d=%h deg=%b got a=%h b=%h c=%h d=%h deg=%b",
                       want.w_a, want.w_b, want.w_c, want.w_d, want.degenerate,
                       got.w_a, got.w_b, got.w_c, got.w_d, got.degenerate);
          end
        end
      end
    end
  end

endmodule

@@ sim.f @@
sv/tbw_pkg.sv
sv/tetrahedron_barycentric_weights_core.sv
sv/tbw_checker.sv
tb/sv/tb_top.sv
